// File: rtl/core/skv_pkg.sv
// Package for the sorted key/value table: sizes, payload and control structs,
// sequencer state type and the level clamp. No dependencies.
`default_nettype none
package skv_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 48;
  localparam int LVL_W    = 3;
  localparam int NEW_W    = 8;

  localparam logic [LVL_W-1:0] LEVEL_MIN     = 3'd1;
  localparam logic [LVL_W-1:0] LEVEL_MAX     = 3'd5;
  localparam logic [LVL_W-1:0] DEFAULT_RESET = 3'd3;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  device_key;
    logic [NEW_W-1:0]  new_level;
  } req_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             was_found;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LVL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] entry_count;
  } skv_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_PROBE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESULT
  } state_t;

  function automatic logic [LVL_W-1:0] clamp_level(input logic [NEW_W-1:0] v);
    logic [LVL_W-1:0] r;
    if (v < NEW_W'(LEVEL_MIN)) begin
      r = LEVEL_MIN;
    end else if (v > NEW_W'(LEVEL_MAX)) begin
      r = LEVEL_MAX;
    end else begin
      r = v[LVL_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/skv_ram.sv
// Entry storage: one write port, one read port with registered read data.
// Depends on skv_pkg.
`default_nettype none
module skv_ram (
  input  wire              clk,
  input  skv_pkg::ram_cmd_t cmd,
  output skv_pkg::entry_t   rd
);
  import skv_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rd <= mem[cmd.raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/skv_cmp.sv
// Shared key comparator used by the search and by the hit probe.
// Depends on skv_pkg.
`default_nettype none
module skv_cmp (
  input  wire [skv_pkg::KEY_W-1:0] a,
  input  wire [skv_pkg::KEY_W-1:0] b,
  output logic                     lt,
  output logic                     eq
);
  import skv_pkg::*;

  assign lt = (a < b);
  assign eq = (a == b);

endmodule
`default_nettype wire

// File: rtl/core/skv_seq.sv
// Sequencer: binary search, hit probe, entry shifting and result hand-off.
// Depends on skv_pkg, skv_cmp and skv_ram.
`default_nettype none
module skv_seq (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      req_valid,
  input  skv_pkg::req_t            req,
  input  wire [skv_pkg::LVL_W-1:0] default_level,
  output logic                     res_valid,
  input  wire                      res_ready,
  output skv_pkg::rsp_t            res,
  output skv_pkg::skv_status_t     status
);
  import skv_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] lo, hi, wptr, count;
  logic [KEY_W-1:0] key;
  logic [LVL_W-1:0] lvl;
  logic             is_store;

  ram_cmd_t cmd;
  entry_t   rd;
  logic     key_lt, key_eq;

  logic [CNT_W-1:0] mid, src;
  logic             full, hit, move_more, lo_lt_hi;

  skv_cmp u_cmp (.a(rd.key), .b(key), .lt(key_lt), .eq(key_eq));
  skv_ram u_ram (.clk(clk), .cmd(cmd), .rd(rd));

  assign lo_lt_hi  = (lo < hi);
  assign mid       = lo + ((hi - lo) >> 1);
  assign full      = (count == CNT_W'(CAPACITY));
  assign hit       = (lo < count) && key_eq;
  // full table: shift down toward entry 0; otherwise shift up from the top
  assign src       = full ? (wptr + CNT_W'(1)) : (wptr - CNT_W'(1));
  assign move_more = full ? (src < lo) : (wptr > lo);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (req_valid) state_next = ST_SRCH;
      ST_SRCH:     state_next = lo_lt_hi ? ST_SRCH_CMP : ST_PROBE;
      ST_SRCH_CMP: state_next = ST_SRCH;
      ST_PROBE: begin
        if (!is_store) begin
          state_next = ST_RESULT;
        end else if (hit) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MOVE_RD;
        end
      end
      ST_MOVE_RD:  state_next = move_more ? ST_MOVE_WR : ST_IDLE;
      ST_MOVE_WR:  state_next = ST_MOVE_RD;
      ST_RESULT:   if (res_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.we    = 1'b0;
    cmd.waddr = lo[ADDR_W-1:0];
    cmd.wdata = '{key: key, level: lvl};
    cmd.raddr = mid[ADDR_W-1:0];
    res_valid = 1'b0;
    case (state)
      ST_SRCH: begin
        if (!lo_lt_hi) cmd.raddr = lo[ADDR_W-1:0];
      end
      ST_PROBE: begin
        if (is_store && hit) cmd.we = 1'b1;
      end
      ST_MOVE_RD: begin
        cmd.raddr = src[ADDR_W-1:0];
        if (!move_more) begin
          cmd.we    = 1'b1;
          cmd.waddr = wptr[ADDR_W-1:0];
        end
      end
      ST_MOVE_WR: begin
        cmd.we    = 1'b1;
        cmd.waddr = wptr[ADDR_W-1:0];
        cmd.wdata = rd;
      end
      ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MOVE_RD && !move_more && !full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lo       <= '0;
        hi       <= count;
        key      <= req.device_key;
        lvl      <= clamp_level(req.new_level);
        is_store <= (req.req_type == REQ_STORE);
      end
      ST_SRCH_CMP: begin
        if (key_lt) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      ST_PROBE: begin
        wptr          <= full ? '0 : count;
        res.was_found <= hit;
        res.level     <= hit ? rd.level : clamp_level(NEW_W'(default_level));
      end
      ST_MOVE_WR: wptr <= src;
      default: ;
    endcase
  end

  assign status.busy        = (state != ST_IDLE);
  assign status.entry_count = count;

endmodule
`default_nettype wire

// File: rtl/core/sorted_key_value_table.sv
// Sorted key/value table with lowest-key eviction, top level.
// Depends on skv_pkg and skv_seq.
//
//  channel  signals                          dir  payload
//  req      req_valid / req_ready            in   skv_pkg::req_t
//  rsp      rsp_valid / rsp_ready            out  skv_pkg::rsp_t (lookups only)
//  cfg      cfg_wr_en                        in   cfg_wr_data = default level
//
// One word at a time. A word runs a binary search over the single entry RAM read
// port, plus for a new key a read and a write of each entry moved.
// Reset clears the entry count and sets the default level to 3; no RAM clear.
// A finished lookup waits in the output register while the next word is taken.
`default_nettype none
module sorted_key_value_table (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      req_valid,
  output logic                     req_ready,
  input  skv_pkg::req_t            req,
  output logic                     rsp_valid,
  input  wire                      rsp_ready,
  output skv_pkg::rsp_t            rsp,
  input  wire                      cfg_wr_en,
  input  wire [skv_pkg::LVL_W-1:0] cfg_wr_data
);
  import skv_pkg::*;

  logic [LVL_W-1:0] default_level;
  logic             res_valid, res_ready;
  rsp_t             res;
  skv_status_t      status;

  assign req_ready = !status.busy;
  assign res_ready = !rsp_valid || rsp_ready;

  skv_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req           (req),
    .default_level (default_level),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .status        (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_level <= DEFAULT_RESET;
    end else if (cfg_wr_en) begin
      default_level <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    status.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> status.busy)
    else $error("accepted word did not start the sequencer");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (status.entry_count != $past(status.entry_count)) |->
      ($past(status.busy) && status.entry_count == $past(status.entry_count) + CNT_W'(1)))
    else $error("entry count changed outside an insert");

endmodule
`default_nettype wire
